/* design/etdr_pkg.sv */
// Shared types and constants of the expert token dispatch router.
// Holds status codes, configuration register indexes, field widths and the
// command and status structs that join the controller and the datapath.
`default_nettype none

package etdr_pkg;

  // Field widths fixed by the item format
  localparam int TOK_W   = 16;
  localparam int ESLOT_W = 4;
  localparam int EID_W   = 8;
  localparam int PRANK_W = 3;
  localparam int SLOT_W  = 16;
  localparam int OFS_W   = 30;
  localparam int STAT_W  = 3;

  // Configuration register widths
  localparam int EPR_W   = 9;
  localparam int RLEN_W  = 15;
  localparam int TCNT_W  = 17;
  localparam int EPT_W   = 5;
  localparam int RCNT_W  = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // One quotient bit per divider step
  localparam int STEP_W = $clog2(EID_W);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_EXPERTS_PER_RANK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOKEN_COUNT       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPERTS_PER_TOKEN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RANK_COUNT        = 3'd4;

  // Configuration reset values
  localparam logic [EPR_W-1:0]  EPR_RESET  = 9'd1;
  localparam logic [RLEN_W-1:0] RLEN_RESET = 15'd4096;
  localparam logic [TCNT_W-1:0] TCNT_RESET = 17'd65536;
  localparam logic [EPT_W-1:0]  EPT_RESET  = 5'd2;
  localparam logic [RCNT_W-1:0] RCNT_RESET = 4'd8;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_ROUTED     = 3'd0,
    ST_BOUNDS     = 3'd1,
    ST_BAD_EXPERT = 3'd2,
    ST_FULL       = 3'd3,
    ST_PRESET     = 3'd4
  } status_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic div_step;
    logic check;
    logic mul_src;
    logic mul_dst;
    logic out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

/* design/expert_token_dispatch_router_core.sv */
// Expert token dispatch router: an accepted item passes through the bit-serial
// divider (8 steps, one quotient bit each), one check state and two passes
// through the shared row-offset multiplier, then waits for a free output register;
// the input stalls until the result is loaded into the output register.
// Reset clears the state machine, the output valid, every rank slot counter
// and loads the configuration registers with their default values.
`default_nettype none

module expert_token_dispatch_router_core #(
  parameter int MAX_RANKS = 8,
  parameter int MAX_SLOTS = 65536
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // configuration write port
  input  wire                              cfg_we_i,
  input  wire [etdr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire [etdr_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // input channel
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire                              req_type_i,
  input  wire [etdr_pkg::TOK_W-1:0]        token_index_i,
  input  wire [etdr_pkg::ESLOT_W-1:0]      choice_idx_i,
  input  wire [etdr_pkg::EID_W-1:0]        expert_sel_i,
  input  wire [etdr_pkg::PRANK_W-1:0]      preset_rank_i,
  input  wire [etdr_pkg::SLOT_W-1:0]       preset_value_i,
  // output channel
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic [etdr_pkg::PRANK_W-1:0]     target_rank_o,
  output logic [etdr_pkg::SLOT_W-1:0]      slot_o,
  output logic [etdr_pkg::OFS_W-1:0]       dest_offset_o,
  output logic [etdr_pkg::OFS_W-1:0]       src_offset_o,
  output logic [etdr_pkg::STAT_W-1:0]      status_o
);

  etdr_pkg::cmd_t cmd;
  etdr_pkg::sts_t sts;

  // Sequence each transfer through the datapath
  etdr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Divide, check, count and compute offsets
  etdr_datapath #(
    .MAX_RANKS (MAX_RANKS),
    .MAX_SLOTS (MAX_SLOTS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .req_type_i     (req_type_i),
    .token_index_i  (token_index_i),
    .choice_idx_i   (choice_idx_i),
    .expert_sel_i   (expert_sel_i),
    .preset_rank_i  (preset_rank_i),
    .preset_value_i (preset_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .target_rank_o  (target_rank_o),
    .slot_o         (slot_o),
    .dest_offset_o  (dest_offset_o),
    .src_offset_o   (src_offset_o),
    .status_o       (status_o),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

endmodule

`default_nettype wire

/* design/etdr_ctrl.sv */
// Sequencing controller of the expert token dispatch router.
// Steps each item through divide, check, multiply and output load;
// uses etdr_pkg for the command and status structs.
`default_nettype none

module etdr_ctrl (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  output logic           in_stall_o,
  input  etdr_pkg::sts_t sts_i,
  output etdr_pkg::cmd_t cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_DIVIDE  = 6'b000010,
    ST_CHECK   = 6'b000100,
    ST_MUL_SRC = 6'b001000,
    ST_MUL_DST = 6'b010000,
    ST_FINISH  = 6'b100000
  } state_e;

  localparam logic [etdr_pkg::STEP_W-1:0] LastStep =
    etdr_pkg::STEP_W'(etdr_pkg::EID_W - 1);

  state_e state_q, state_d;
  logic [etdr_pkg::STEP_W-1:0] step_q, step_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (step_q == LastStep) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = ST_MUL_SRC;
      end
      ST_MUL_SRC: begin
        cmd_o.mul_src = 1'b1;
        state_d       = ST_MUL_DST;
      end
      ST_MUL_DST: begin
        cmd_o.mul_dst = 1'b1;
        state_d       = ST_FINISH;
      end
      ST_FINISH: begin
        // hold until the output register can take the result
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  // Advance the divider step count, wrapping after the last step
  assign step_d = cmd_o.div_step ? step_q + 1'b1 : step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  a_check_after_divide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CHECK |-> $past(state_q) == ST_DIVIDE)
    else $error("check entered without a divide");

  a_step_wrapped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CHECK |-> step_q == '0)
    else $error("divider step count did not wrap");

  a_load_starts_divide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == ST_DIVIDE && step_q == '0)
    else $error("accepted item did not start the divider");

endmodule

`default_nettype wire

/* design/etdr_datapath.sv */
// Datapath of the expert token dispatch router: configuration registers,
// bit-serial divider, rank slot counters, shared multiplier, output register.
// Uses etdr_pkg for widths, codes and the command and status structs.
`default_nettype none

module etdr_datapath #(
  parameter int MAX_RANKS = 8,
  parameter int MAX_SLOTS = 65536
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // configuration
  input  wire                              cfg_we_i,
  input  wire [etdr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire [etdr_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // input payload
  input  wire                              req_type_i,
  input  wire [etdr_pkg::TOK_W-1:0]        token_index_i,
  input  wire [etdr_pkg::ESLOT_W-1:0]      choice_idx_i,
  input  wire [etdr_pkg::EID_W-1:0]        expert_sel_i,
  input  wire [etdr_pkg::PRANK_W-1:0]      preset_rank_i,
  input  wire [etdr_pkg::SLOT_W-1:0]       preset_value_i,
  // output channel
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic [etdr_pkg::PRANK_W-1:0]     target_rank_o,
  output logic [etdr_pkg::SLOT_W-1:0]      slot_o,
  output logic [etdr_pkg::OFS_W-1:0]       dest_offset_o,
  output logic [etdr_pkg::OFS_W-1:0]       src_offset_o,
  output logic [etdr_pkg::STAT_W-1:0]      status_o,
  // control
  input  etdr_pkg::cmd_t                   cmd_i,
  output etdr_pkg::sts_t                   sts_o
);

  localparam int CntW  = ($clog2(MAX_SLOTS + 1) > etdr_pkg::SLOT_W) ?
                         $clog2(MAX_SLOTS + 1) : etdr_pkg::SLOT_W;
  localparam int RIdxW = (MAX_RANKS > 1) ? $clog2(MAX_RANKS) : 1;
  localparam int EidW  = etdr_pkg::EID_W;
  localparam int EprW  = etdr_pkg::EPR_W;
  localparam int ProdW = etdr_pkg::SLOT_W + etdr_pkg::RLEN_W;

  // Configuration registers
  logic [etdr_pkg::EPR_W-1:0]  epr_q;
  logic [etdr_pkg::RLEN_W-1:0] rlen_q;
  logic [etdr_pkg::TCNT_W-1:0] tcnt_q;
  logic [etdr_pkg::EPT_W-1:0]  ept_q;
  logic [etdr_pkg::RCNT_W-1:0] rcnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epr_q  <= etdr_pkg::EPR_RESET;
      rlen_q <= etdr_pkg::RLEN_RESET;
      tcnt_q <= etdr_pkg::TCNT_RESET;
      ept_q  <= etdr_pkg::EPT_RESET;
      rcnt_q <= etdr_pkg::RCNT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        etdr_pkg::CFG_EXPERTS_PER_RANK:  epr_q  <= cfg_data_i[etdr_pkg::EPR_W-1:0];
        etdr_pkg::CFG_ROW_LENGTH:        rlen_q <= cfg_data_i[etdr_pkg::RLEN_W-1:0];
        etdr_pkg::CFG_TOKEN_COUNT:       tcnt_q <= cfg_data_i[etdr_pkg::TCNT_W-1:0];
        etdr_pkg::CFG_EXPERTS_PER_TOKEN: ept_q  <= cfg_data_i[etdr_pkg::EPT_W-1:0];
        etdr_pkg::CFG_RANK_COUNT:        rcnt_q <= cfg_data_i[etdr_pkg::RCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Captured input item
  logic                          req_q;
  logic [etdr_pkg::TOK_W-1:0]    tok_q;
  logic [etdr_pkg::ESLOT_W-1:0]  eslot_q;
  logic [etdr_pkg::PRANK_W-1:0]  prank_q;
  logic [etdr_pkg::SLOT_W-1:0]   pval_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q   <= req_type_i;
      tok_q   <= token_index_i;
      eslot_q <= choice_idx_i;
      prank_q <= preset_rank_i;
      pval_q  <= preset_value_i;
    end
  end

  // Restoring divider: quotient register starts as the dividend
  logic [EprW-1:0] divisor;
  logic [EprW-1:0] rem_q;
  logic [EidW-1:0] quo_q;
  logic [EprW:0]   trial;
  logic            trial_ge;

  assign divisor  = (epr_q == '0) ? EprW'(1) : epr_q;
  assign trial    = {rem_q, quo_q[EidW-1]};
  assign trial_ge = trial >= {1'b0, divisor};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rem_q <= '0;
      quo_q <= expert_sel_i;
    end else if (cmd_i.div_step) begin
      rem_q <= trial_ge ? EprW'(trial - {1'b0, divisor}) : trial[EprW-1:0];
      quo_q <= {quo_q[EidW-2:0], trial_ge};
    end
  end

  // Check the item against bounds, rank range and counter fill
  logic [EidW-1:0]  rank_wide;
  logic             rank_in_range;
  logic [RIdxW-1:0] chk_idx;
  logic [CntW-1:0]  chk_cnt;
  logic             bounds_bad;
  logic             counter_full;
  etdr_pkg::status_e chk_status;

  assign rank_wide     = req_q ? EidW'(prank_q) : quo_q;
  assign rank_in_range = {1'b0, rank_wide} < (EidW + 1)'(MAX_RANKS);
  assign chk_idx       = rank_wide[RIdxW-1:0];
  assign bounds_bad    = ({1'b0, tok_q} >= tcnt_q) || ({1'b0, eslot_q} >= ept_q);

  logic [CntW-1:0] cnt_q [MAX_RANKS];

  assign chk_cnt      = cnt_q[chk_idx];
  assign counter_full = chk_cnt >= CntW'(MAX_SLOTS);

  always_comb begin
    if (req_q) begin
      chk_status = rank_in_range ? etdr_pkg::ST_PRESET : etdr_pkg::ST_BAD_EXPERT;
    end else if (bounds_bad) begin
      chk_status = etdr_pkg::ST_BOUNDS;
    end else if (!rank_in_range || (quo_q >= EidW'(rcnt_q))) begin
      chk_status = etdr_pkg::ST_BAD_EXPERT;
    end else if (counter_full) begin
      chk_status = etdr_pkg::ST_FULL;
    end else begin
      chk_status = etdr_pkg::ST_ROUTED;
    end
  end

  // Rank slot counters: take a slot on a route, load on a preset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < MAX_RANKS; r++) begin
        cnt_q[r] <= '0;
      end
    end else if (cmd_i.check) begin
      if (chk_status == etdr_pkg::ST_PRESET) begin
        cnt_q[chk_idx] <= CntW'(pval_q);
      end else if (chk_status == etdr_pkg::ST_ROUTED) begin
        cnt_q[chk_idx] <= chk_cnt + CntW'(1);
      end
    end
  end

  // Result fields of the check
  etdr_pkg::status_e             res_status_q;
  logic [etdr_pkg::PRANK_W-1:0]  res_rank_q;
  logic [etdr_pkg::SLOT_W-1:0]   res_slot_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.check) begin
      res_status_q <= chk_status;
      case (chk_status)
        etdr_pkg::ST_PRESET: begin
          res_rank_q <= prank_q;
          res_slot_q <= pval_q;
        end
        etdr_pkg::ST_ROUTED: begin
          res_rank_q <= quo_q[etdr_pkg::PRANK_W-1:0];
          res_slot_q <= chk_cnt[etdr_pkg::SLOT_W-1:0];
        end
        default: begin
          res_rank_q <= '0;
          res_slot_q <= '0;
        end
      endcase
    end
  end

  // Shared multiplier: token row offset, then slot row offset
  logic [etdr_pkg::SLOT_W-1:0] mul_a;
  logic [ProdW-1:0]            prod;
  logic [etdr_pkg::OFS_W-1:0]  src_ofs_q;
  logic [etdr_pkg::OFS_W-1:0]  dst_ofs_q;

  assign mul_a = cmd_i.mul_src ? tok_q : res_slot_q;
  assign prod  = ProdW'(mul_a) * ProdW'(rlen_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_src) begin
      src_ofs_q <= prod[etdr_pkg::OFS_W-1:0];
    end
    if (cmd_i.mul_dst) begin
      dst_ofs_q <= prod[etdr_pkg::OFS_W-1:0];
    end
  end

  // Output register
  logic                          out_valid_q;
  logic [etdr_pkg::PRANK_W-1:0]  out_rank_q;
  logic [etdr_pkg::SLOT_W-1:0]   out_slot_q;
  logic [etdr_pkg::OFS_W-1:0]    out_dofs_q;
  logic [etdr_pkg::OFS_W-1:0]    out_sofs_q;
  etdr_pkg::status_e             out_status_q;
  logic                          routed;

  assign routed          = (res_status_q == etdr_pkg::ST_ROUTED);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_rank_q   <= res_rank_q;
      out_slot_q   <= res_slot_q;
      out_dofs_q   <= routed ? dst_ofs_q : '0;
      out_sofs_q   <= routed ? src_ofs_q : '0;
      out_status_q <= res_status_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign target_rank_o = out_rank_q;
  assign slot_o        = out_slot_q;
  assign dest_offset_o = out_dofs_q;
  assign src_offset_o  = out_sofs_q;
  assign status_o      = out_status_q;

  a_counter_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.check && chk_status == etdr_pkg::ST_ROUTED) |=>
      cnt_q[$past(chk_idx)] == $past(chk_cnt) + CntW'(1))
    else $error("routed item did not advance its rank counter");

  a_failed_offsets_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q != etdr_pkg::ST_ROUTED) |->
      (out_dofs_q == '0 && out_sofs_q == '0))
    else $error("offsets not cleared on a result that was not routed");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("output register overwritten while stalled");

endmodule

`default_nettype wire
